// ----- rtl/core/ght_pkg.sv -----
// ----------------------------------------------------------------------------
// Generational handle table package
// Shared types, constants and helper functions for the handle table, its
// shared adder unit and its checker.
// ----------------------------------------------------------------------------
package ght_pkg;

   // Field widths of the request and response.
   localparam int unsigned PTR_W       = 64;
   localparam int unsigned TOKEN_W     = 32;
   localparam int unsigned GEN_W       = 12;
   localparam int unsigned IDX_FIELD_W = 20;
   localparam int unsigned GEN_SHIFT   = 20;
   localparam int unsigned WIDE_W      = PTR_W + 1;

   // Largest generation value; the next one wraps back to one.
   localparam logic [GEN_W-1:0] GEN_MAX = 12'hFFF;

   // Default number of slots, index 0 included.
   localparam int unsigned SLOTS_DEFAULT = 1024;

   typedef enum logic [1:0] {
      OP_REGISTER   = 2'd0,
      OP_RESOLVE    = 2'd1,
      OP_INVALIDATE = 2'd2,
      OP_CLEAR      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_NULL    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_REG_POP,
      S_REG_GEN,
      S_RES_CHK,
      S_INV_RD,
      S_INV_LO,
      S_INV_HI
   } state_type;

   typedef struct packed {
      op_type             opcode;
      logic [PTR_W-1:0]   pointer_in;
      logic [TOKEN_W-1:0] token_in;
      logic [PTR_W-1:0]   range_base;
      logic [PTR_W-1:0]   range_size;
   } req_type;

   typedef struct packed {
      logic [TOKEN_W-1:0] token_out;
      logic [PTR_W-1:0]   pointer_out;
      status_type         status;
   } rsp_type;

   // Operand bundle for the shared adder/subtractor.
   typedef struct packed {
      logic              subtract;
      logic [WIDE_W-1:0] op_a;
      logic [WIDE_W-1:0] op_b;
   } alu_req_type;

   typedef struct packed {
      logic [WIDE_W-1:0] result;
      logic              carry;
   } alu_rsp_type;

   // Generation after a bump: zero and the top value both go to one.
   function automatic logic [GEN_W-1:0] gen_next(input logic [GEN_W-1:0] g);
      logic [GEN_W-1:0] r;
      if (g == '0 || g >= GEN_MAX) begin
         r = GEN_W'(1);
      end else begin
         r = g + GEN_W'(1);
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/generational_handle_table_top.sv -----
// A register of a reused slot pops the free stack and reads the slot before writing;
// invalidate walks each slot from one up to the next fresh index, with two adder
// compares for each slot of nonzero generation.
// The result strobe comes in the cycle in which busy falls; it cannot stall.
// Reset clears control state only; the fresh-index fill mark makes the table
// read as empty at once, with no clearing pass, and a clear request does the same.
// ----------------------------------------------------------------------------
// Generational handle table
// Maps pointers to generation-tagged tokens with a free stack of slots,
// resolves tokens, invalidates address ranges with a slot walk and clears the table.
// ----------------------------------------------------------------------------
module generational_handle_table_top #(
   parameter int unsigned SLOTS = ght_pkg::SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ght_pkg::req_type req_data,
   output logic             rsp_valid,
   output ght_pkg::rsp_type rsp_data
);

   localparam int unsigned IDX_W = $clog2(SLOTS);
   localparam int unsigned CNT_W = $clog2(SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

   ght_pkg::state_type state_ff, state_in;
   ght_pkg::req_type   req_ff, req_in;
   ght_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   fresh_ff, fresh_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   walk_ff, walk_in;
   logic [IDX_W-1:0]   pop_idx_ff, pop_idx_in;
   logic [ght_pkg::WIDE_W-1:0] hi_ff, hi_in;
   logic               ge_ff, ge_in;

   // Slot memories (pointer and generation share addresses).
   logic                     slot_wr_en, slot_rd_en;
   logic [IDX_W-1:0]         slot_wr_addr, slot_rd_addr;
   logic [ght_pkg::PTR_W-1:0] ptr_wr_data, ptr_rd_data;
   logic [ght_pkg::GEN_W-1:0] gen_wr_data, gen_rd_data;

   // Free stack memory.
   logic             free_wr_en, free_rd_en;
   logic [IDX_W-1:0] free_wr_addr, free_rd_addr, free_wr_data, free_rd_data;

   ght_pkg::alu_req_type alu_req;
   ght_pkg::alu_rsp_type alu_rsp;

   // Token fields of a resolve request.
   logic [ght_pkg::GEN_W-1:0]       tok_gen;
   logic [ght_pkg::IDX_FIELD_W-1:0] tok_idx;
   logic                            res_bad;
   logic [ght_pkg::GEN_W-1:0]       pop_gen;

   assign tok_gen = req_ff.token_in[ght_pkg::TOKEN_W-1:ght_pkg::GEN_SHIFT];
   assign tok_idx = req_ff.token_in[ght_pkg::IDX_FIELD_W-1:0];
   assign res_bad = (tok_gen == '0) || (tok_idx == '0) ||
                    ({1'b0, tok_idx} >= (ght_pkg::IDX_FIELD_W + 1)'(fresh_ff));

   // A reused slot that still has generation zero starts at one.
   assign pop_gen = (gen_rd_data == '0) ? ght_pkg::GEN_W'(1) : gen_rd_data;

   ght_ram #(.WIDTH(ght_pkg::PTR_W), .DEPTH(SLOTS)) u_ptr_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (ptr_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (ptr_rd_data)
   );

   ght_ram #(.WIDTH(ght_pkg::GEN_W), .DEPTH(SLOTS)) u_gen_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (gen_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (gen_rd_data)
   );

   ght_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_wr_en),
      .wr_addr (free_wr_addr),
      .wr_data (free_wr_data),
      .rd_en   (free_rd_en),
      .rd_addr (free_rd_addr),
      .rd_data (free_rd_data)
   );

   ght_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ght_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         fresh_ff     <= CNT_W'(1);
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fresh_ff     <= fresh_in;
         count_ff     <= count_in;
      end
   end

   // Payload and walk registers.
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      walk_ff    <= walk_in;
      pop_idx_ff <= pop_idx_in;
      hi_ff      <= hi_in;
      ge_ff      <= ge_in;
   end

   // Sequencer: next state, memory controls and adder operands.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = '0;
      rsp_valid_in = 1'b0;
      fresh_in     = fresh_ff;
      count_in     = count_ff;
      walk_in      = walk_ff;
      pop_idx_in   = pop_idx_ff;
      hi_in        = hi_ff;
      ge_in        = ge_ff;

      slot_wr_en   = 1'b0;
      slot_wr_addr = '0;
      ptr_wr_data  = '0;
      gen_wr_data  = '0;
      slot_rd_en   = 1'b0;
      slot_rd_addr = '0;
      free_wr_en   = 1'b0;
      free_wr_addr = '0;
      free_wr_data = '0;
      free_rd_en   = 1'b0;
      free_rd_addr = '0;

      // The adder sums the range end unless a walk compare needs it.
      alu_req.subtract = 1'b0;
      alu_req.op_a     = {1'b0, req_ff.range_base};
      alu_req.op_b     = {1'b0, req_ff.range_size};

      unique case (state_ff)
         ght_pkg::S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ght_pkg::S_DECODE;
            end
         end

         ght_pkg::S_DECODE: begin
            unique case (req_ff.opcode)
               ght_pkg::OP_REGISTER: begin
                  priority if (req_ff.pointer_in == '0) begin
                     rsp_in.status = ght_pkg::STATUS_NULL;
                     rsp_valid_in  = 1'b1;
                     state_in      = ght_pkg::S_IDLE;
                  end else if (count_ff != '0) begin
                     // Pop the most recently freed slot.
                     free_rd_en   = 1'b1;
                     free_rd_addr = IDX_W'(count_ff - CNT_W'(1));
                     count_in     = count_ff - CNT_W'(1);
                     state_in     = ght_pkg::S_REG_POP;
                  end else if (fresh_ff >= SLOTS_CNT) begin
                     rsp_in.status = ght_pkg::STATUS_FULL;
                     rsp_valid_in  = 1'b1;
                     state_in      = ght_pkg::S_IDLE;
                  end else begin
                     // A fresh slot always starts at generation one.
                     slot_wr_en   = 1'b1;
                     slot_wr_addr = fresh_ff[IDX_W-1:0];
                     ptr_wr_data  = req_ff.pointer_in;
                     gen_wr_data  = ght_pkg::GEN_W'(1);
                     fresh_in     = fresh_ff + CNT_W'(1);
                     rsp_in.token_out = {ght_pkg::GEN_W'(1),
                                         ght_pkg::IDX_FIELD_W'(fresh_ff[IDX_W-1:0])};
                     rsp_valid_in = 1'b1;
                     state_in     = ght_pkg::S_IDLE;
                  end
               end

               ght_pkg::OP_RESOLVE: begin
                  if (res_bad) begin
                     rsp_in.status = ght_pkg::STATUS_INVALID;
                     rsp_valid_in  = 1'b1;
                     state_in      = ght_pkg::S_IDLE;
                  end else begin
                     slot_rd_en   = 1'b1;
                     slot_rd_addr = tok_idx[IDX_W-1:0];
                     state_in     = ght_pkg::S_RES_CHK;
                  end
               end

               ght_pkg::OP_INVALIDATE: begin
                  if (req_ff.range_base == '0 || req_ff.range_size == '0) begin
                     rsp_valid_in = 1'b1;
                     state_in     = ght_pkg::S_IDLE;
                  end else begin
                     // Range end kept to 65 bits so it never wraps.
                     hi_in    = alu_rsp.result;
                     walk_in  = CNT_W'(1);
                     state_in = ght_pkg::S_INV_RD;
                  end
               end

               ght_pkg::OP_CLEAR: begin
                  fresh_in     = CNT_W'(1);
                  count_in     = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = ght_pkg::S_IDLE;
               end
            endcase
         end

         ght_pkg::S_REG_POP: begin
            if (free_rd_data == '0 || CNT_W'(free_rd_data) >= SLOTS_CNT) begin
               rsp_in.status = ght_pkg::STATUS_FULL;
               rsp_valid_in  = 1'b1;
               state_in      = ght_pkg::S_IDLE;
            end else begin
               slot_rd_en   = 1'b1;
               slot_rd_addr = free_rd_data;
               pop_idx_in   = free_rd_data;
               state_in     = ght_pkg::S_REG_GEN;
            end
         end

         ght_pkg::S_REG_GEN: begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = pop_idx_ff;
            ptr_wr_data  = req_ff.pointer_in;
            gen_wr_data  = pop_gen;
            rsp_in.token_out = {pop_gen, ght_pkg::IDX_FIELD_W'(pop_idx_ff)};
            rsp_valid_in = 1'b1;
            state_in     = ght_pkg::S_IDLE;
         end

         ght_pkg::S_RES_CHK: begin
            if (gen_rd_data == tok_gen) begin
               rsp_in.pointer_out = ptr_rd_data;
            end else begin
               rsp_in.status = ght_pkg::STATUS_INVALID;
            end
            rsp_valid_in = 1'b1;
            state_in     = ght_pkg::S_IDLE;
         end

         ght_pkg::S_INV_RD: begin
            if (walk_ff >= fresh_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ght_pkg::S_IDLE;
            end else begin
               slot_rd_en   = 1'b1;
               slot_rd_addr = walk_ff[IDX_W-1:0];
               state_in     = ght_pkg::S_INV_LO;
            end
         end

         ght_pkg::S_INV_LO: begin
            // Lower bound: pointer minus base, no borrow means inside.
            alu_req.subtract = 1'b1;
            alu_req.op_a     = {1'b0, ptr_rd_data};
            alu_req.op_b     = {1'b0, req_ff.range_base};
            if (gen_rd_data == '0) begin
               walk_in  = walk_ff + CNT_W'(1);
               state_in = ght_pkg::S_INV_RD;
            end else begin
               ge_in    = alu_rsp.carry;
               state_in = ght_pkg::S_INV_HI;
            end
         end

         ght_pkg::S_INV_HI: begin
            // Upper bound: a borrow means the pointer is below the range end.
            alu_req.subtract = 1'b1;
            alu_req.op_a     = {1'b0, ptr_rd_data};
            alu_req.op_b     = hi_ff;
            if (ge_ff && !alu_rsp.carry) begin
               slot_wr_en   = 1'b1;
               slot_wr_addr = walk_ff[IDX_W-1:0];
               ptr_wr_data  = '0;
               gen_wr_data  = ght_pkg::gen_next(gen_rd_data);
               if (count_ff < SLOTS_CNT) begin
                  free_wr_en   = 1'b1;
                  free_wr_addr = count_ff[IDX_W-1:0];
                  free_wr_data = walk_ff[IDX_W-1:0];
                  count_in     = count_ff + CNT_W'(1);
               end
            end
            walk_in  = walk_ff + CNT_W'(1);
            state_in = ght_pkg::S_INV_RD;
         end

         default: begin
            state_in = ght_pkg::S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ght_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/ght_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ght_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write and registered read; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ght_alu.sv -----
// ----------------------------------------------------------------------------
// Handle table shared adder
// One 65-bit adder/subtractor used for the range end sum and for both
// bound compares of the invalidate walk.
// ----------------------------------------------------------------------------
module ght_alu (
   input  ght_pkg::alu_req_type alu_req,
   output ght_pkg::alu_rsp_type alu_rsp
);

   logic [ght_pkg::WIDE_W:0]   sum;
   logic [ght_pkg::WIDE_W-1:0] b_eff;

   // Subtraction is a + ~b + 1; carry out set means no borrow (a >= b).
   assign b_eff = alu_req.subtract ? ~alu_req.op_b : alu_req.op_b;
   assign sum   = {1'b0, alu_req.op_a} + {1'b0, b_eff}
                + (ght_pkg::WIDE_W + 1)'(alu_req.subtract);

   assign alu_rsp.result = sum[ght_pkg::WIDE_W-1:0];
   assign alu_rsp.carry  = sum[ght_pkg::WIDE_W];

endmodule

// ----- rtl/core/ght_checker.sv -----
// ----------------------------------------------------------------------------
// Handle table port checker
// Watches the top-level ports for sequencing and result-format rules.
// ----------------------------------------------------------------------------
module ght_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input ght_pkg::rsp_type rsp_data
);

   // A transfer in makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // Results never come in two consecutive cycles.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A result appears only as the block becomes free again.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   // Any failing status carries neither a token nor a pointer.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ght_pkg::STATUS_OK) |->
         (rsp_data.token_out == '0 && rsp_data.pointer_out == '0))
      else $error("failing status with nonzero payload");

   // A result never carries both a token and a pointer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.token_out == '0 || rsp_data.pointer_out == '0))
      else $error("result carries both token and pointer");

endmodule

bind generational_handle_table_top ght_checker u_ght_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
